### rtl/q8bdp_pkg.sv
// shared types and constants for the q8 block dot product
package q8bdp_pkg;

    // lanes that fit in one 64-bit input field
    localparam int FIELD_LANES = 8;
    localparam int PROD_W      = 16;

    // default quiet nans as produced by the arithmetic
    localparam logic [31:0] SGL_QNAN = 32'hFFC0_0000;
    localparam logic [63:0] DBL_QNAN = 64'hFFF8_0000_0000_0000;

    // request from the block front end to the float unit
    typedef struct packed {
        logic start;
        logic emit;
    } fpu_req_t;

    // status of the float unit
    typedef struct packed {
        logic busy;
        logic push;
    } fpu_rsp_t;

endpackage

### rtl/q8_block_dot_product_top.sv
// top level of the q8 block dot product
//
//  channel  signals                                         dir  width
//  in       in_valid in_stall a_lanes b_lanes scale_a       in   64/64/32/32/1
//           scale_b vector_end
//  out      out_valid out_stall dot_value                   out  64
//
// items that do not close a block are taken back to back.
// a block close runs the float sequencer, whose run length is set by the
// normalize shifts of the scale product, the term and the double add;
// no item is taken while it runs.
// reset clears block sum, item count, running total and the output beat.
// a result held under out_stall stalls only the next vector end, in its FIN state.
module q8_block_dot_product_top
    import q8bdp_pkg::*;
#(
    parameter int LANES      = 8,
    parameter int BLOCK_SIZE = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] a_lanes,
    input  logic [63:0] b_lanes,
    input  logic [31:0] scale_a,
    input  logic [31:0] scale_b,
    input  logic        vector_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] dot_value
);

    localparam int NL    = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
    localparam int IPB   = (BLOCK_SIZE + NL - 1) / NL;
    localparam int ACC_W = $clog2(IPB * NL * 16384 + 1) + 1;

    logic                    accept;
    logic                    close;
    logic signed [ACC_W-1:0] blk_sum;
    logic signed [PROD_W-1:0] prod [NL];
    fpu_req_t                req;
    fpu_rsp_t                rsp;
    logic [63:0]             result;
    logic                    out_free;
    logic                    out_valid_reg, out_valid_next;
    logic [63:0]             dot_reg, dot_next;

    assign in_stall = rsp.busy;
    assign accept   = in_valid && !in_stall;

    // lanes
    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        q8bdp_lane u_lane
        (
            .a    (a_lanes[8*i +: 8]),
            .b    (b_lanes[8*i +: 8]),
            .prod (prod[i])
        );
    end

    q8bdp_merge #(
        .NL    (NL),
        .IPB   (IPB),
        .ACC_W (ACC_W)
    ) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .vector_end (vector_end),
        .prod       (prod),
        .blk_sum    (blk_sum),
        .close      (close)
    );

    assign req.start = accept && close;
    assign req.emit  = vector_end;

    q8bdp_fpu #(
        .ACC_W (ACC_W)
    ) u_fpu
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .sa       (scale_a),
        .sb       (scale_b),
        .blk_sum  (blk_sum),
        .out_free (out_free),
        .rsp      (rsp),
        .result   (result)
    );

    // output beat register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        dot_next       = dot_reg;
        if (rsp.push)
        begin
            out_valid_next = 1'b1;
            dot_next       = result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg <= dot_next;
    end

    assign out_valid = out_valid_reg;
    assign dot_value = dot_reg;

endmodule

### rtl/q8bdp_lane.sv
// one lane: signed byte by signed byte product
module q8bdp_lane
    import q8bdp_pkg::*;
(
    input  logic [7:0]               a,
    input  logic [7:0]               b,
    output logic signed [PROD_W-1:0] prod
);

    // 8x8 signed multiply
    assign prod = $signed(a) * $signed(b);

endmodule

### rtl/q8bdp_merge.sv
// merge of lane products into the exact block sum, block close control
module q8bdp_merge
    import q8bdp_pkg::*;
#(
    parameter int NL    = 8,
    parameter int IPB   = 4,
    parameter int ACC_W = 21
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     vector_end,
    input  logic signed [PROD_W-1:0] prod [NL],
    output logic signed [ACC_W-1:0]  blk_sum,
    output logic                     close
);

    localparam int CNT_W = (IPB > 1) ? $clog2(IPB) : 1;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic signed [ACC_W-1:0] lane_sum;

    // adder over the lanes
    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < NL; i++)
        begin
            lane_sum = lane_sum + ACC_W'(prod[i]);
        end
    end

    assign blk_sum = acc_reg + lane_sum;
    assign close   = vector_end || (cnt_reg == CNT_W'(IPB - 1));

    // accumulator and item count of the open block
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (close)
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            else
            begin
                acc_next = blk_sum;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/q8bdp_fpu.sv
// float sequencer: scale product, term and double running total
module q8bdp_fpu
    import q8bdp_pkg::*;
#(
    parameter int ACC_W = 21
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fpu_req_t                req,
    input  logic [31:0]             sa,
    input  logic [31:0]             sb,
    input  logic signed [ACC_W-1:0] blk_sum,
    input  logic                    out_free,
    output fpu_rsp_t                rsp,
    output logic [63:0]             result
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FMUL  = 4'd1;
    localparam logic [3:0] ST_FNORM = 4'd2;
    localparam logic [3:0] ST_FRND  = 4'd3;
    localparam logic [3:0] ST_TMUL  = 4'd4;
    localparam logic [3:0] ST_TNORM = 4'd5;
    localparam logic [3:0] ST_ADD1  = 4'd6;
    localparam logic [3:0] ST_ADD2  = 4'd7;
    localparam logic [3:0] ST_ANORM = 4'd8;
    localparam logic [3:0] ST_ARND  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0]              state_reg, state_next;
    logic [31:0]             sa_reg, sa_next;
    logic [31:0]             sb_reg, sb_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic                    emit_reg, emit_next;
    logic [47:0]             p_reg, p_next;
    logic signed [9:0]       fe_reg, fe_next;
    logic [31:0]             sp_reg, sp_next;
    logic [52:0]             q_reg, q_next;
    logic [11:0]             te_reg, te_next;
    logic [63:0]             term_reg, term_next;
    logic [63:0]             tot_reg, tot_next;
    logic [55:0]             ax_reg, ax_next;
    logic [55:0]             ay_reg, ay_next;
    logic [12:0]             ae_reg, ae_next;
    logic                    asub_reg, asub_next;
    logic                    sgn_reg, sgn_next;
    logic [56:0]             s_reg, s_next;

    // scale operand decode
    logic [7:0]  ea, eb, eau, ebu;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, fsgn;
    // single rounding
    logic signed [9:0] ext_sh;
    logic [5:0]        fsh;
    logic [95:0]       fwide;
    logic [23:0]       fmant;
    logic              fg, fst, frnd;
    logic [7:0]        fexp;
    // term decode
    logic [7:0]          espf, esp;
    logic [23:0]         msp;
    logic                sp_nan, sp_inf, sp_zero, sum_zero, tsgn;
    logic [ACC_W-1:0]    abs_v;
    logic [ACC_W+23:0]   prod_q;
    // double add decode
    logic        xnan, ynan, xinf, yinf, swap;
    logic [63:0] big, lit;
    logic [10:0] ebf, elf, ebd, eld, dexp;
    logic [52:0] mbig, mlit;
    logic [5:0]  dcap;
    logic [111:0] awide;
    logic [56:0] asum;
    logic        ag, ast, arnd;
    logic [10:0] aexp;

    assign ea     = sa_reg[30:23];
    assign eb     = sb_reg[30:23];
    assign eau    = (ea == 8'd0) ? 8'd1 : ea;
    assign ebu    = (eb == 8'd0) ? 8'd1 : eb;
    assign ma     = {(ea != 8'd0), sa_reg[22:0]};
    assign mb     = {(eb != 8'd0), sb_reg[22:0]};
    assign nan_a  = (ea == 8'hFF) && (sa_reg[22:0] != '0);
    assign nan_b  = (eb == 8'hFF) && (sb_reg[22:0] != '0);
    assign inf_a  = (ea == 8'hFF) && (sa_reg[22:0] == '0);
    assign inf_b  = (eb == 8'hFF) && (sb_reg[22:0] == '0);
    assign zero_a = (ea == 8'd0) && (sa_reg[22:0] == '0);
    assign zero_b = (eb == 8'd0) && (sb_reg[22:0] == '0);
    assign fsgn   = sa_reg[31] ^ sb_reg[31];

    // right shift of the normalized product, more for subnormal results
    assign ext_sh = 10'sd25 - fe_reg;
    assign fsh    = (fe_reg >= 10'sd1) ? 6'd24 :
                    (ext_sh > 10'sd50) ? 6'd50 : ext_sh[5:0];
    assign fwide  = {p_reg, 48'b0} >> fsh;
    assign fmant  = fwide[71:48];
    assign fg     = fwide[47];
    assign fst    = |fwide[46:0];
    assign frnd   = fg && (fst || fmant[0]);
    assign fexp   = (fe_reg >= 10'sd1) ? fe_reg[7:0] : 8'd0;

    assign espf     = sp_reg[30:23];
    assign esp      = (espf == 8'd0) ? 8'd1 : espf;
    assign msp      = {(espf != 8'd0), sp_reg[22:0]};
    assign sp_nan   = (espf == 8'hFF) && (sp_reg[22:0] != '0);
    assign sp_inf   = (espf == 8'hFF) && (sp_reg[22:0] == '0);
    assign sp_zero  = (espf == 8'd0) && (sp_reg[22:0] == '0);
    assign sum_zero = (sum_reg == '0);
    assign tsgn     = sum_zero ? sp_reg[31] : (sum_reg[ACC_W-1] ^ sp_reg[31]);
    assign abs_v    = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : ACC_W'(sum_reg);
    assign prod_q   = abs_v * msp;

    assign xnan = (tot_reg[62:52] == 11'h7FF) && (tot_reg[51:0] != '0);
    assign ynan = (term_reg[62:52] == 11'h7FF) && (term_reg[51:0] != '0);
    assign xinf = (tot_reg[62:52] == 11'h7FF) && (tot_reg[51:0] == '0);
    assign yinf = (term_reg[62:52] == 11'h7FF) && (term_reg[51:0] == '0);
    assign swap = term_reg[62:0] > tot_reg[62:0];
    assign big  = swap ? term_reg : tot_reg;
    assign lit  = swap ? tot_reg : term_reg;
    assign ebf  = big[62:52];
    assign elf  = lit[62:52];
    assign ebd  = (ebf == 11'd0) ? 11'd1 : ebf;
    assign eld  = (elf == 11'd0) ? 11'd1 : elf;
    assign mbig = {(ebf != 11'd0), big[51:0]};
    assign mlit = {(elf != 11'd0), lit[51:0]};
    assign dexp = ebd - eld;
    assign dcap = (dexp > 11'd63) ? 6'd63 : dexp[5:0];
    assign awide = {mlit, 3'b0, 56'b0} >> dcap;
    assign asum = asub_reg ? ({1'b0, ax_reg} - {1'b0, ay_reg})
                           : ({1'b0, ax_reg} + {1'b0, ay_reg});
    assign ag   = s_reg[2];
    assign ast  = s_reg[1] | s_reg[0];
    assign arnd = ag && (ast || s_reg[3]);
    assign aexp = s_reg[55] ? ae_reg[10:0] : 11'd0;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sum_next   = sum_reg;
        emit_next  = emit_reg;
        p_next     = p_reg;
        fe_next    = fe_reg;
        sp_next    = sp_reg;
        q_next     = q_reg;
        te_next    = te_reg;
        term_next  = term_reg;
        tot_next   = tot_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        ae_next    = ae_reg;
        asub_next  = asub_reg;
        sgn_next   = sgn_reg;
        s_next     = s_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    sa_next    = sa;
                    sb_next    = sb;
                    sum_next   = blk_sum;
                    emit_next  = req.emit;
                    state_next = ST_FMUL;
                end
            end
            // scale product: specials or mantissa multiply
            ST_FMUL:
            begin
                state_next = ST_TMUL;
                if (nan_a)
                begin
                    sp_next = sa_reg | 32'h0040_0000;
                end
                else if (nan_b)
                begin
                    sp_next = sb_reg | 32'h0040_0000;
                end
                else if ((inf_a && zero_b) || (inf_b && zero_a))
                begin
                    sp_next = SGL_QNAN;
                end
                else if (inf_a || inf_b)
                begin
                    sp_next = {fsgn, 8'hFF, 23'b0};
                end
                else if (zero_a || zero_b)
                begin
                    sp_next = {fsgn, 31'b0};
                end
                else
                begin
                    p_next     = ma * mb;
                    fe_next    = $signed({2'b0, eau}) + $signed({2'b0, ebu}) - 10'sd126;
                    state_next = ST_FNORM;
                end
            end
            // bring the leading one to the top, a byte or a bit a cycle
            ST_FNORM:
            begin
                if (p_reg[47])
                begin
                    state_next = ST_FRND;
                end
                else if (p_reg[47:40] == 8'd0)
                begin
                    p_next  = {p_reg[39:0], 8'b0};
                    fe_next = fe_reg - 10'sd8;
                end
                else
                begin
                    p_next  = {p_reg[46:0], 1'b0};
                    fe_next = fe_reg - 10'sd1;
                end
            end
            ST_FRND:
            begin
                if (fe_reg >= 10'sd255)
                begin
                    sp_next = {fsgn, 8'hFF, 23'b0};
                end
                else
                begin
                    sp_next = {fsgn, {fexp, fmant[22:0]} + {30'b0, frnd}};
                end
                state_next = ST_TMUL;
            end
            // block sum times widened scale product, always exact
            ST_TMUL:
            begin
                state_next = ST_ADD1;
                sgn_next   = tsgn;
                if (sp_nan)
                begin
                    term_next = {sp_reg[31], 11'h7FF, sp_reg[22:0], 29'b0};
                end
                else if (sp_inf)
                begin
                    term_next = sum_zero ? DBL_QNAN : {tsgn, 11'h7FF, 52'b0};
                end
                else if (sp_zero || sum_zero)
                begin
                    term_next = {tsgn, 63'b0};
                end
                else
                begin
                    q_next     = 53'(prod_q);
                    te_next    = {4'b0, esp} + 12'd925;
                    state_next = ST_TNORM;
                end
            end
            ST_TNORM:
            begin
                if (q_reg[52])
                begin
                    term_next  = {sgn_reg, te_reg[10:0], q_reg[51:0]};
                    state_next = ST_ADD1;
                end
                else if (q_reg[52:45] == 8'd0)
                begin
                    q_next  = {q_reg[44:0], 8'b0};
                    te_next = te_reg - 12'd8;
                end
                else
                begin
                    q_next  = {q_reg[51:0], 1'b0};
                    te_next = te_reg - 12'd1;
                end
            end
            // double add: specials, swap and align
            ST_ADD1:
            begin
                state_next = ST_FIN;
                if (xnan)
                begin
                    tot_next = tot_reg | 64'h0008_0000_0000_0000;
                end
                else if (ynan)
                begin
                    tot_next = term_reg | 64'h0008_0000_0000_0000;
                end
                else if (xinf && yinf && (tot_reg[63] != term_reg[63]))
                begin
                    tot_next = DBL_QNAN;
                end
                else if (xinf)
                begin
                    tot_next = tot_reg;
                end
                else if (yinf)
                begin
                    tot_next = term_reg;
                end
                else
                begin
                    ax_next    = {mbig, 3'b0};
                    ay_next    = awide[111:56] | {55'b0, |awide[55:0]};
                    ae_next    = {2'b0, ebd};
                    sgn_next   = big[63];
                    asub_next  = tot_reg[63] ^ term_reg[63];
                    state_next = ST_ADD2;
                end
            end
            ST_ADD2:
            begin
                if (asum == '0)
                begin
                    tot_next   = {(asub_reg ? 1'b0 : sgn_reg), 63'b0};
                    state_next = ST_FIN;
                end
                else
                begin
                    s_next     = asum;
                    state_next = ST_ANORM;
                end
            end
            ST_ANORM:
            begin
                if (s_reg[56])
                begin
                    s_next  = {1'b0, s_reg[56:2], s_reg[1] | s_reg[0]};
                    ae_next = ae_reg + 13'd1;
                end
                else if (s_reg[55] || (ae_reg == 13'd1))
                begin
                    state_next = ST_ARND;
                end
                else if ((s_reg[55:48] == 8'd0) && (ae_reg > 13'd8))
                begin
                    s_next  = {s_reg[48:0], 8'b0};
                    ae_next = ae_reg - 13'd8;
                end
                else
                begin
                    s_next  = {s_reg[55:0], 1'b0};
                    ae_next = ae_reg - 13'd1;
                end
            end
            ST_ARND:
            begin
                if (ae_reg >= 13'd2047)
                begin
                    tot_next = {sgn_reg, 11'h7FF, 52'b0};
                end
                else
                begin
                    tot_next = {sgn_reg, {aexp, s_reg[54:3]} + {62'b0, arnd}};
                end
                state_next = ST_FIN;
            end
            // hand the total out on vector end, then clear it
            ST_FIN:
            begin
                if (!emit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    tot_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.busy = (state_reg != ST_IDLE);
    assign rsp.push = (state_reg == ST_FIN) && emit_reg && out_free;
    assign result   = tot_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tot_reg   <= tot_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sum_reg  <= sum_next;
        emit_reg <= emit_next;
        p_reg    <= p_next;
        fe_reg   <= fe_next;
        sp_reg   <= sp_next;
        q_reg    <= q_next;
        te_reg   <= te_next;
        term_reg <= term_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        ae_reg   <= ae_next;
        asub_reg <= asub_next;
        sgn_reg  <= sgn_next;
        s_reg    <= s_next;
    end

endmodule
